FILE: rtl/three_channel_moving_average_scaler_assert.svh
// Assertion macros for the moving average scaler.
`ifndef THREE_CHANNEL_MOVING_AVERAGE_SCALER_ASSERT_SVH
`define THREE_CHANNEL_MOVING_AVERAGE_SCALER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCMAS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCMAS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCMAS_ASSERT_IMP(lbl, ante, cons, msg)
`define TCMAS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/tcmas_pkg.sv
`timescale 1ns / 1ps

package tcmas_pkg;

    localparam int NUM_CH      = 3;
    localparam int SAMPLE_W    = 12;
    localparam int GAIN_W      = 24;
    localparam int MEAN_W      = 16;
    localparam int SCALED_W    = 20;
    localparam int MEAN_FRAC   = 4;
    localparam int SCALE_SHIFT = 16;
    localparam int FRAME_W     = NUM_CH * SAMPLE_W;
    localparam int CFG_IDX_W   = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [GAIN_W-1:0]    gain_t;
    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [FRAME_W-1:0]   frame_t;

    // Register indexes of the configuration port.
    localparam cfg_idx_t REG_VOUT_GAIN = 2'd0;
    localparam cfg_idx_t REG_IOUT_GAIN = 2'd1;
    localparam cfg_idx_t REG_VIN_GAIN  = 2'd2;

    // Gain values after reset, Q16 thousandths per converter step.
    localparam gain_t VOUT_GAIN_RST = 24'd52800;
    localparam gain_t IOUT_GAIN_RST = 24'd52800;
    localparam gain_t VIN_GAIN_RST  = 24'd580762;

endpackage

FILE: rtl/three_channel_moving_average_scaler.sv
// Pipeline: after the window read at the input accept edge, the running sum, the gain multiply
// and the division by WINDOW (a reciprocal multiplication) take one stage each up to m_valid.
// Throughput: one item per cycle; one window read and one write-back per item. A low m_ready
// stalls the pipeline, and s_ready falls once all four stages hold an item and m_ready is low.
// Reset (aresetn, synchronous, active low) clears sums, pointer and pipeline, and reloads gains.
// Window entries carry valid bits cleared at once by reset, so there is no clearing pass.
`timescale 1ns / 1ps
`include "three_channel_moving_average_scaler_assert.svh"

module three_channel_moving_average_scaler #(
    parameter int WINDOW = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  tcmas_pkg::cfg_idx_t              cfg_index,
    input  logic [tcmas_pkg::GAIN_W-1:0]     cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tcmas_pkg::SAMPLE_W-1:0]   s_vout_sample,
    input  logic [tcmas_pkg::SAMPLE_W-1:0]   s_iout_sample,
    input  logic [tcmas_pkg::SAMPLE_W-1:0]   s_vin_sample,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tcmas_pkg::MEAN_W-1:0]     m_vout_mean,
    output logic [tcmas_pkg::MEAN_W-1:0]     m_iout_mean,
    output logic [tcmas_pkg::MEAN_W-1:0]     m_vin_mean,
    output logic [tcmas_pkg::SCALED_W-1:0]   m_vout_scaled,
    output logic [tcmas_pkg::SCALED_W-1:0]   m_iout_scaled,
    output logic [tcmas_pkg::SCALED_W-1:0]   m_vin_scaled
);

    localparam int NCH     = tcmas_pkg::NUM_CH;
    localparam int SW      = tcmas_pkg::SAMPLE_W;
    localparam int GW      = tcmas_pkg::GAIN_W;
    localparam int QW      = tcmas_pkg::SCALED_W;
    localparam int SUM_MAX = ((1 << SW) - 1) * WINDOW;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PROD_W  = SUM_W + GW;
    localparam int DIVW    = PROD_W - tcmas_pkg::SCALE_SHIFT;
    localparam int REC_SH  = DIVW + $clog2(WINDOW);
    localparam int REC_W   = DIVW + 1;
    localparam int RP_W    = DIVW + REC_W;
    localparam int NLANE   = 2 * NCH;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW - 1);
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(SUM_MAX);

    // The reciprocal of WINDOW rounded up gives the exact floored quotient for every
    // dividend below 2**DIVW, because its rounding error stays under 2**REC_SH.
    localparam logic [63:0]      REC_NUM = (64'd1 << REC_SH) + 64'(WINDOW) - 64'd1;
    localparam logic [REC_W-1:0] REC_MUL = REC_W'(REC_NUM / 64'(WINDOW));

    // Window memory: one frame per entry, valid bits make unwritten entries read as zero.
    tcmas_pkg::frame_t win_mem [WINDOW];
    logic [WINDOW-1:0] win_vld_reg;

    tcmas_pkg::gain_t  gain_reg [NCH];
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [SUM_W-1:0]  sum_reg  [NCH];
    logic [SUM_W-1:0]  sum_next [NCH];

    // Read stage.
    logic               v1_reg;
    tcmas_pkg::frame_t  s1_new_reg;
    logic [PTR_W-1:0]   s1_slot_reg;
    tcmas_pkg::frame_t  rd_data_reg;
    logic               rd_vld_reg;
    logic               fwd_reg;
    tcmas_pkg::frame_t  fwd_data_reg;
    tcmas_pkg::frame_t  old_frame;

    // Multiply stage.
    logic               v2_reg;
    logic [SUM_W-1:0]   s2_sum_reg [NCH];
    logic [PROD_W-1:0]  prod       [NCH];
    logic [DIVW-1:0]    div_in     [NLANE];

    // Division stage: dividends, then quotients taken from the reciprocal product.
    logic               v3_reg;
    logic [DIVW-1:0]    s3_div_reg [NLANE];
    logic [RP_W-1:0]    rec_prod   [NLANE];
    logic               v4_reg;
    logic [QW-1:0]      q_reg      [NLANE];

    logic s4_rdy;
    logic s3_rdy;
    logic s2_rdy;
    logic s1_rdy;
    logic s1_fire;
    logic accept;
    logic sum_ok;

    // Ready chain, each stage takes an item when empty or when it moves on.
    assign s4_rdy  = !v4_reg || m_ready;
    assign s3_rdy  = !v3_reg || s4_rdy;
    assign s2_rdy  = !v2_reg || s3_rdy;
    assign s1_rdy  = !v1_reg || s2_rdy;
    assign s1_fire = v1_reg && s2_rdy;
    assign s_ready = s1_rdy;
    assign accept  = s_valid && s1_rdy;

    assign wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;

    // With a one-entry window the entry being read is the one written in the same cycle.
    assign old_frame = fwd_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '0);

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            sum_next[c] = sum_reg[c] - SUM_W'(old_frame[c*SW +: SW])
                        + SUM_W'(s1_new_reg[c*SW +: SW]);
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            prod[c] = PROD_W'(s2_sum_reg[c]) * PROD_W'(gain_reg[c]);
            div_in[c] = DIVW'({s2_sum_reg[c], {tcmas_pkg::MEAN_FRAC{1'b0}}});
            div_in[NCH+c] = prod[c][PROD_W-1:tcmas_pkg::SCALE_SHIFT];
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            rec_prod[l] = RP_W'(s3_div_reg[l]) * RP_W'(REC_MUL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg[0] <= tcmas_pkg::VOUT_GAIN_RST;
            gain_reg[1] <= tcmas_pkg::IOUT_GAIN_RST;
            gain_reg[2] <= tcmas_pkg::VIN_GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tcmas_pkg::REG_VOUT_GAIN: gain_reg[0] <= cfg_wdata;
                tcmas_pkg::REG_IOUT_GAIN: gain_reg[1] <= cfg_wdata;
                tcmas_pkg::REG_VIN_GAIN:  gain_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            win_vld_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                sum_reg[c] <= '0;
            end
        end else begin
            if (accept) begin
                wp_reg <= wp_next;
            end
            if (s1_rdy) begin
                v1_reg <= s_valid;
            end
            if (s1_fire) begin
                win_vld_reg[s1_slot_reg] <= 1'b1;
                for (int c = 0; c < NCH; c++) begin
                    sum_reg[c] <= sum_next[c];
                end
            end
            if (s2_rdy) begin
                v2_reg <= v1_reg;
            end
            if (s3_rdy) begin
                v3_reg <= v2_reg;
            end
            if (s4_rdy) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            win_mem[s1_slot_reg] <= s1_new_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_new_reg   <= {s_vin_sample, s_iout_sample, s_vout_sample};
            s1_slot_reg  <= wp_reg;
            rd_data_reg  <= win_mem[wp_reg];
            rd_vld_reg   <= win_vld_reg[wp_reg];
            fwd_reg      <= s1_fire && (s1_slot_reg == wp_reg);
            fwd_data_reg <= s1_new_reg;
        end
        if (s1_fire) begin
            for (int c = 0; c < NCH; c++) begin
                s2_sum_reg[c] <= sum_next[c];
            end
        end
        if (v2_reg && s3_rdy) begin
            for (int l = 0; l < NLANE; l++) begin
                s3_div_reg[l] <= div_in[l];
            end
        end
        if (v3_reg && s4_rdy) begin
            for (int l = 0; l < NLANE; l++) begin
                q_reg[l] <= rec_prod[l][REC_SH +: QW];
            end
        end
    end

    assign m_valid       = v4_reg;
    assign m_vout_mean   = q_reg[0][tcmas_pkg::MEAN_W-1:0];
    assign m_iout_mean   = q_reg[1][tcmas_pkg::MEAN_W-1:0];
    assign m_vin_mean    = q_reg[2][tcmas_pkg::MEAN_W-1:0];
    assign m_vout_scaled = q_reg[NCH];
    assign m_iout_scaled = q_reg[NCH+1];
    assign m_vin_scaled  = q_reg[NCH+2];

    assign sum_ok = (sum_reg[0] <= SUM_LIMIT) && (sum_reg[1] <= SUM_LIMIT)
                 && (sum_reg[2] <= SUM_LIMIT);

    `TCMAS_ASSERT_IMP(a_sum_range, 1'b1, sum_ok, "running sum exceeds window maximum")
    `TCMAS_ASSERT_NXT(a_wp_hold, !accept, $stable(wp_reg), "write pointer moved without an item")
    `TCMAS_ASSERT_NXT(a_vld_set, s1_fire, win_vld_reg[$past(s1_slot_reg)], "written slot not valid")
    `TCMAS_ASSERT_IMP(a_fwd_only_same, v1_reg && fwd_reg, WINDOW == 1, "unexpected forwarding")

endmodule
